/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file hf2u_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/hf2u_pkg.sv */
// ----------------------------------------------------------------------------
// hf2u_pkg
// Shared types and constants of the half-float to pixel level converter.
// ----------------------------------------------------------------------------
package hf2u_pkg;

  localparam int unsigned HALF_W  = 16;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 32;

  // Register word index
  localparam logic REG_DEPTH_MODE = 1'b0;

  // Depth mode codes
  localparam logic MODE_8BIT  = 1'b0;
  localparam logic MODE_16BIT = 1'b1;

  localparam logic [15:0] SCALE_8BIT  = 16'd255;
  localparam logic [15:0] SCALE_16BIT = 16'd65535;
  localparam logic [4:0]  EXP_SPECIAL = 5'd31;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [BYTE_W-1:0]  high_byte;
    logic [BYTE_W-1:0]  low_byte;
  } pix_res_t;

endpackage

/* rtl/half_float_to_unorm_pixel_core.sv */
// ----------------------------------------------------------------------------
// half_float_to_unorm_pixel_core
// Streams binary16 samples in, unsigned normalised pixel levels out.
// ----------------------------------------------------------------------------
// Use:
//   in_  : one binary16 sample per transfer in in_tdata[15:0].
//   out_ : level [15:0], high byte [23:16], low byte [31:24].
//   cfg_ : APB port, one register at byte 0: depth_mode (0 = 8-bit, scale
//          255; 1 = 16-bit, scale 65535). Write only while the stream idles.
// Path: an accepted sample passes the input register, the conversion logic
//   and the result register before it reaches out_tdata.
// Throughput: one sample per clock unless a held result stalls the pipe; set
//   by the single conversion stage with its 11x16 multiply, round and shift.
// Stall: a held result freezes the two-stage pipe; in_tready then stays high
//   only while the input register is empty.
// Reset: rst_n synchronous, clears both valid flags and sets 8-bit mode.
// ----------------------------------------------------------------------------
module half_float_to_unorm_pixel_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] half_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [15:0] level, [23:16] high_byte, [31:24] low_byte
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                 depth_mode;
  logic                 in_vld_r, in_vld_nxt;
  logic [15:0]          half_r, half_nxt;
  logic                 out_vld_r, out_vld_nxt;
  hf2u_pkg::pix_res_t   res;
  hf2u_pkg::pix_res_t   res_r, res_nxt;
  logic                 advance;

  hf2u_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .depth_mode (depth_mode)
  );

  hf2u_conv u_conv (
    .half_bits  (half_r),
    .depth_mode (depth_mode),
    .res        (res)
  );

  // result slot free or being drained this cycle
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = advance || !in_vld_r;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    half_nxt    = half_r;
    out_vld_nxt = out_vld_r;
    res_nxt     = res_r;
    if (advance) begin
      out_vld_nxt = in_vld_r;
      res_nxt     = res;
    end
    if (in_tready) begin
      in_vld_nxt = in_tvalid;
      half_nxt   = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    half_r <= half_nxt;
    res_r  <= res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {res_r.low_byte, res_r.high_byte, res_r.level};

endmodule

/* rtl/hf2u_cfg.sv */
// ----------------------------------------------------------------------------
// hf2u_cfg
// APB register block holding the depth mode.
// ----------------------------------------------------------------------------
module hf2u_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hf2u_pkg::CFG_AW-1:0] paddr,
  input  logic [hf2u_pkg::CFG_DW-1:0] pwdata,
  output logic [hf2u_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output logic                        depth_mode
);

  logic depth_mode_r;
  logic depth_mode_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    depth_mode_nxt = depth_mode_r;
    if (wr_en && (paddr[hf2u_pkg::CFG_AW-1] == hf2u_pkg::REG_DEPTH_MODE)) begin
      depth_mode_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_mode_r <= hf2u_pkg::MODE_8BIT;
    end else begin
      depth_mode_r <= depth_mode_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[hf2u_pkg::CFG_AW-1] == hf2u_pkg::REG_DEPTH_MODE) begin
      prdata = {{(hf2u_pkg::CFG_DW-1){1'b0}}, depth_mode_r};
    end
  end

  assign depth_mode = depth_mode_r;

endmodule

/* rtl/hf2u_conv.sv */
// ----------------------------------------------------------------------------
// hf2u_conv
// Combinational half to level conversion: scale, round to single, round to
// integer, saturate; negative, Inf, NaN and values from 2^31 give level 0.
// ----------------------------------------------------------------------------
module hf2u_conv (
  input  logic [hf2u_pkg::HALF_W-1:0] half_bits,
  input  logic                        depth_mode,
  output hf2u_pkg::pix_res_t          res
);

  logic        sgn;
  logic [4:0]  ex;
  logic [9:0]  fr;
  logic [10:0] mant;
  logic [15:0] coef;
  logic [26:0] prod;
  logic [24:0] q1;
  logic        g1;
  logic        st1;
  logic [1:0]  k1;
  logic [24:0] q1_rnd;
  logic [27:0] prod_r;
  logic [4:0]  e_eff;
  logic [33:0] int_left;
  logic [55:0] ext;
  logic [27:0] q2;
  logic        up2;
  logic [33:0] int_val;
  logic [15:0] maxv;
  logic [15:0] level;

  always_comb begin
    sgn  = half_bits[15];
    ex   = half_bits[14:10];
    fr   = half_bits[9:0];
    mant = (ex == 5'd0) ? {1'b0, fr} : {1'b1, fr};
    coef = (depth_mode == hf2u_pkg::MODE_16BIT) ? hf2u_pkg::SCALE_16BIT
                                                : hf2u_pkg::SCALE_8BIT;
    maxv = coef;
    // full 27-bit product: operands widened before the multiply
    prod = {16'd0, mant} * {11'd0, coef};

    // round product to a 24-bit significand, ties to even
    q1  = prod[24:0];
    g1  = 1'b0;
    st1 = 1'b0;
    k1  = 2'd0;
    if (prod[26]) begin
      q1 = {1'b0, prod[26:3]}; g1 = prod[2]; st1 = |prod[1:0]; k1 = 2'd3;
    end else if (prod[25]) begin
      q1 = {1'b0, prod[25:2]}; g1 = prod[1]; st1 = prod[0];    k1 = 2'd2;
    end else if (prod[24]) begin
      q1 = {1'b0, prod[24:1]}; g1 = prod[0]; st1 = 1'b0;       k1 = 2'd1;
    end
    q1_rnd = q1 + {24'd0, g1 & (st1 | q1[0])};
    prod_r = {3'd0, q1_rnd} << k1;

    // value = prod_r * 2^(e_eff-25)
    e_eff    = (ex == 5'd0) ? 5'd1 : ex;
    int_left = {6'd0, prod_r} << (e_eff - 5'd25);
    ext      = {prod_r, 28'd0} >> (5'd25 - e_eff);
    q2       = ext[55:28];
    up2      = ext[27] & ((|ext[26:0]) | q2[0]);
    if (e_eff >= 5'd25) begin
      int_val = int_left;
    end else begin
      int_val = {5'd0, 29'({1'b0, q2} + {28'd0, up2})};
    end

    if (sgn || (ex == hf2u_pkg::EXP_SPECIAL) || (int_val[33:31] != 3'd0)) begin
      level = '0;
    end else if (int_val > {18'd0, maxv}) begin
      level = maxv;
    end else begin
      level = int_val[15:0];
    end

    res.level = level;
    if (depth_mode == hf2u_pkg::MODE_16BIT) begin
      res.high_byte = level[15:8];
      res.low_byte  = level[7:0];
    end else begin
      res.high_byte = level[7:0];
      res.low_byte  = '0;
    end
  end

endmodule

/* rtl/hf2u_checker.sv */
// ----------------------------------------------------------------------------
// hf2u_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hf2u_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        cfg_pready
);

  `ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")
  `ASSERT_CLK(a_bytes, out_tvalid |-> (out_tdata[23:16] == out_tdata[15:8]) || (out_tdata[31:24] == 8'd0 && out_tdata[15:8] == 8'd0 && out_tdata[23:16] == out_tdata[7:0]), "byte split inconsistent")
  `ASSERT_CLK(a_no_bubble, !out_tvalid |-> in_tready && cfg_pready, "input blocked with empty output")

endmodule

bind half_float_to_unorm_pixel_core hf2u_checker u_hf2u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the half-float to pixel level converter: streams
// binary16 samples in 8-bit and 16-bit depth, predicts each level exactly
// and compares every output transfer field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;     // [15:0] half_bits
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // [15:0] level, [23:16] high_byte, [31:24] low_byte
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  half_float_to_unorm_pixel_core DUT (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Testbench copy of depth_mode and the stream bookkeeping
  logic                  depth_q;
  logic [15:0]           sample_q[$];     // samples waiting to be driven
  hf2u_pkg::pix_res_t    level_q[$];      // predicted results, oldest first
  int                    n_sent, n_got, n_err, n_mode16;
  bit                    quiet;           // no idling while set
  bit                    taken;

  // Exact widen, multiply with rounding to single precision, then round to
  // nearest even integer and saturate.
  function automatic hf2u_pkg::pix_res_t predict_level(logic [15:0] h, logic mode16);
    hf2u_pkg::pix_res_t r;
    logic [63:0] p, q, rem, hlf, v;
    int          e, k, len;
    logic [31:0] lvl, lim;
    lvl = 0;
    lim = mode16 ? 32'd65535 : 32'd255;
    if (h[14:10] != hf2u_pkg::EXP_SPECIAL) begin
      if (h[14:10] == 5'd0) begin
        p = {54'd0, h[9:0]};
        e = -24;
      end else begin
        p = {53'd0, 1'b1, h[9:0]};
        e = int'(h[14:10]) - 25;
      end
      p = p * (mode16 ? 64'd65535 : 64'd255);
      // negative and zero products both end at level 0
      if (p != 0 && !h[15]) begin
        len = 0;
        for (int i = 0; i < 64; i++) if (p[i]) len = i + 1;
        if (len > 24) begin
          k   = len - 24;
          q   = p >> k;
          rem = p & ((64'd1 << k) - 1);
          hlf = 64'd1 << (k - 1);
          if (rem > hlf || (rem == hlf && q[0])) q++;
          p = q;
          e += k;
        end
        if (e >= 0) begin
          v = p << e;
          lvl = (v >= 64'h8000_0000) ? 32'd0 : v[31:0];   // indefinite at and above 2^31
        end else begin
          k   = -e;
          q   = p >> k;
          rem = p & ((64'd1 << k) - 1);
          hlf = 64'd1 << (k - 1);
          if (rem > hlf || (rem == hlf && q[0])) q++;
          lvl = q[31:0];
        end
        if (lvl > lim) lvl = lim;
      end
    end
    r.level     = lvl[15:0];
    r.high_byte = mode16 ? lvl[15:8] : lvl[7:0];
    r.low_byte  = mode16 ? lvl[7:0]  : 8'd0;
    return r;
  endfunction

  // Input side: accept at the rising edge, refill at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      level_q.push_back(predict_level(in_tdata, depth_q));
      n_sent++;
      if (depth_q == hf2u_pkg::MODE_16BIT) n_mode16++;
      taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (taken || !in_tvalid)) begin
      taken = 1'b0;
      if ((quiet || $urandom_range(99) >= 13) && sample_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= sample_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
        in_tdata  <= 16'($urandom);
      end
    end
    if (rst_n) out_tready <= quiet || ($urandom_range(99) >= 13);
  end

  // Output side: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    hf2u_pkg::pix_res_t exp_r, got_r;
    if (rst_n && out_tvalid && out_tready) begin
      got_r = hf2u_pkg::pix_res_t'({out_tdata[15:0], out_tdata[23:16], out_tdata[31:24]});
      if (level_q.size() == 0) begin
        $error("unexpected result transfer, tdata %h", out_tdata);
        n_err++;
      end else begin
        exp_r = level_q.pop_front();
        if (got_r.level != exp_r.level) begin
          $error("level: expected %0d, actual %0d", exp_r.level, got_r.level);
          n_err++;
        end
        if (got_r.high_byte != exp_r.high_byte) begin
          $error("high_byte: expected %0d, actual %0d", exp_r.high_byte, got_r.high_byte);
          n_err++;
        end
        if (got_r.low_byte != exp_r.low_byte) begin
          $error("low_byte: expected %0d, actual %0d", exp_r.low_byte, got_r.low_byte);
          n_err++;
        end
      end
      n_got++;
    end
  end

  // Register write: setup then access; takes effect at the access edge
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_pready && addr == 3'(hf2u_pkg::REG_DEPTH_MODE)) depth_q = data[0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Block until every queued sample has come back, plus pipe latency
  task automatic drain();
    wait (sample_q.size() == 0 && !in_tvalid && n_got == n_sent);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: sample_q.push_back(16'($urandom));
        1: sample_q.push_back(16'($urandom_range(16'h3C00)));   // 0.0 .. 1.0
        2: sample_q.push_back({1'b0, 5'($urandom_range(10, 15)), 10'($urandom)});
        default: sample_q.push_back({1'b0, 5'($urandom_range(16, 30)), 10'($urandom)});
      endcase
    end
  endtask

  logic [15:0] corner[$] = '{16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h0400,
    16'h3800, 16'h3BFF, 16'h3C00, 16'h3C01, 16'hBC00, 16'h8001, 16'h7BFF,
    16'h7C00, 16'hFC00, 16'h7E00, 16'h7C01, 16'hFFFF, 16'h5BF8, 16'h1C04,
    16'h0C04, 16'h2401, 16'h5555, 16'hAAAA, 16'h4000};

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    depth_q = hf2u_pkg::MODE_8BIT; quiet = 1'b0; taken = 1'b0;
    n_sent = 0; n_got = 0; n_err = 0; n_mode16 = 0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed corners at reset depth, then 16-bit depth
    foreach (corner[i]) sample_q.push_back(corner[i]);
    drain();
    reg_write(3'(hf2u_pkg::REG_DEPTH_MODE), 32'(hf2u_pkg::MODE_16BIT));
    foreach (corner[i]) sample_q.push_back(corner[i]);
    drain();
    // write to an unmapped word must leave the depth alone
    reg_write(3'd4, 32'(hf2u_pkg::MODE_8BIT));
    reg_write(3'd4, 32'hFFFF_FFFF);

    // Random phases alternating depth, one without idling
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(3'(hf2u_pkg::REG_DEPTH_MODE), (ph % 2) ? 32'hFFFF_FFFF : 32'hFFFF_FFFE);
      quiet = (ph == 3);
      load_random(170);
      drain();
    end
    quiet = 1'b0;

    $display("Covered %0d samples (%0d at 16-bit depth), corners and random data.",
             n_sent, n_mode16);
    if (n_err == 0 && level_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/hf2u_pkg.sv
rtl/hf2u_cfg.sv
rtl/hf2u_conv.sv
rtl/half_float_to_unorm_pixel_core.sv
rtl/hf2u_checker.sv
tb/sv/tb.sv
